@@ sv/jose_pkg.sv @@
// shared widths, defaults and cell control type for the josephus order block
package jose_pkg;

    localparam int RING_W    = 7;
    localparam int STEP_W    = 10;
    localparam int N_MAX_DEF = 64;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

@@ sv/jose_cell.sv @@
// one ring cell: holds the live flag of one position and rotates it toward the head
module jose_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jose_pkg::cell_ctrl_t ctrl,
    input  logic                 load_val,
    input  logic                 nbr,
    input  logic                 head,
    input  logic                 tail,
    output logic                 alive
);

    logic alive_reg;
    logic alive_next;

    always_comb
    begin
        alive_next = alive_reg;
        if (ctrl.load)
        begin
            alive_next = load_val;
        end
        else if (ctrl.shift)
        begin
            // the tail of the live ring takes the head bit back in
            alive_next = tail ? head : nbr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= 1'b0;
        end
        else
        begin
            alive_reg <= alive_next;
        end
    end

    assign alive = alive_reg;

endmodule

@@ sv/jose_mod.sv @@
// shift-subtract remainder unit, one dividend bit per cycle
module jose_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [jose_pkg::STEP_W-1:0]   dividend,
    input  logic [jose_pkg::RING_W-1:0]   divisor,
    output logic                          done,
    output logic [jose_pkg::RING_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(jose_pkg::STEP_W);

    logic                          run_reg;
    logic                          run_next;
    logic                          done_reg;
    logic                          done_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic [jose_pkg::STEP_W-1:0]   dvd_reg;
    logic [jose_pkg::STEP_W-1:0]   dvd_next;
    logic [jose_pkg::RING_W-1:0]   div_reg;
    logic [jose_pkg::RING_W-1:0]   div_next;
    logic [jose_pkg::RING_W-1:0]   rem_reg;
    logic [jose_pkg::RING_W-1:0]   rem_next;
    logic [jose_pkg::RING_W-1:0]   trial;

    always_comb
    begin
        // remainder stays below the divisor, so its top bit is free for the shift
        trial     = {rem_reg[jose_pkg::RING_W-2:0], dvd_reg[jose_pkg::STEP_W-1]};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(jose_pkg::STEP_W - 1);
            dvd_next = dividend;
            div_next = divisor;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = (trial >= div_reg) ? (trial - div_reg) : trial;
            dvd_next = {dvd_reg[jose_pkg::STEP_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ sv/josephus_elimination_order_top.sv @@
// josephus elimination order: rotating ring of live-flag cells with a remainder unit
//
//   channel   signals                          beat
//   request   start, busy, ring_size,          start high while busy low
//             step_count
//   result    result_strobe, position, last    one cycle per strobe, no stall
//
// each removal first runs the remainder unit (reduces k-1 modulo the live count) and
// then makes one ring rotation per position walked, at most n positions per removal.
// reset clears the ring, the counters and the control state; nothing is pending.
// busy stays high from the accepted beat until the last removal leaves the ring.
// each result comes from an output register; the strobe is high for one cycle, position and last hold until the next.
module josephus_elimination_order_top #(
    parameter int N_MAX = jose_pkg::N_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [jose_pkg::RING_W-1:0]   ring_size,
    input  logic [jose_pkg::STEP_W-1:0]   step_count,
    output logic                          result_strobe,
    output logic [jose_pkg::RING_W-1:0]   position,
    output logic                          last
);

    localparam int IDX_W  = $clog2(N_MAX);
    localparam int RING_W = jose_pkg::RING_W;
    localparam int STEP_W = jose_pkg::STEP_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MOD  = 3'b010,
        S_WALK = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [RING_W-1:0]     n_reg;
    logic [RING_W-1:0]     n_next;
    logic [RING_W-1:0]     left_reg;
    logic [RING_W-1:0]     left_next;
    logic [RING_W-1:0]     steps_reg;
    logic [RING_W-1:0]     steps_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [STEP_W-1:0]     km1_reg;
    logic [STEP_W-1:0]     km1_next;
    logic                  strobe_reg;
    logic                  strobe_next;
    logic [RING_W-1:0]     pos_reg;
    logic [RING_W-1:0]     pos_next;
    logic                  last_reg;
    logic                  last_next;

    logic [RING_W-1:0]     n_eff;
    logic [STEP_W-1:0]     km1_eff;
    logic                  accept;
    logic                  hit;
    logic                  remove;
    logic                  mod_go;
    logic [STEP_W-1:0]     mod_dvd;
    logic [RING_W-1:0]     mod_div;
    logic                  mod_done;
    logic [RING_W-1:0]     mod_rem;
    logic [IDX_W-1:0]      idx_adv;
    logic                  head_bit;
    jose_pkg::cell_ctrl_t  cell_ctrl;
    logic [N_MAX-1:0]      alive;

    assign n_eff   = (ring_size > RING_W'(N_MAX)) ? RING_W'(N_MAX) : ring_size;
    assign km1_eff = (step_count == '0) ? '0 : (step_count - STEP_W'(1));
    assign accept  = start && (state_reg == S_IDLE);
    assign hit     = alive[0];
    assign remove  = (state_reg == S_WALK) && hit && (steps_reg == RING_W'(1));
    assign head_bit = alive[0] && !remove;
    assign idx_adv = (RING_W'(idx_reg) == (n_reg - RING_W'(1))) ? '0 : (idx_reg + IDX_W'(1));

    always_comb
    begin
        cell_ctrl.load  = accept && (n_eff != '0);
        cell_ctrl.shift = (state_reg == S_WALK);
    end

    genvar gi;
    generate
        for (gi = 0; gi < N_MAX; gi++)
        begin : g_cell
            logic nbr;
            logic load_val;
            logic tail;

            if (gi < N_MAX - 1)
            begin : g_inner
                assign nbr = alive[gi+1];
            end
            else
            begin : g_end
                assign nbr = 1'b0;
            end

            assign load_val = (RING_W'(gi) < n_eff);
            assign tail     = (RING_W'(gi) == (n_reg - RING_W'(1)));

            jose_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .load_val (load_val),
                .nbr      (nbr),
                .head     (head_bit),
                .tail     (tail),
                .alive    (alive[gi])
            );
        end
    endgenerate

    always_comb
    begin
        mod_go  = 1'b0;
        mod_dvd = km1_reg;
        mod_div = left_reg - RING_W'(1);
        if (state_reg == S_IDLE)
        begin
            mod_go  = accept && (n_eff != '0);
            mod_dvd = km1_eff;
            mod_div = n_eff;
        end
        else if (remove && (left_reg != RING_W'(1)))
        begin
            mod_go = 1'b1;
        end
    end

    jose_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (mod_go),
        .dividend  (mod_dvd),
        .divisor   (mod_div),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        left_next   = left_reg;
        steps_next  = steps_reg;
        idx_next    = idx_reg;
        km1_next    = km1_reg;
        strobe_next = 1'b0;
        pos_next    = pos_reg;
        last_next   = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (n_eff != '0))
                begin
                    n_next     = n_eff;
                    left_next  = n_eff;
                    km1_next   = km1_eff;
                    idx_next   = '0;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    steps_next = mod_rem + RING_W'(1);
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                idx_next = idx_adv;
                if (remove)
                begin
                    strobe_next = 1'b1;
                    pos_next    = RING_W'(idx_reg) + RING_W'(1);
                    last_next   = (left_reg == RING_W'(1));
                    left_next   = left_reg - RING_W'(1);
                    state_next  = (left_reg == RING_W'(1)) ? S_IDLE : S_MOD;
                end
                else if (hit)
                begin
                    steps_next = steps_reg - RING_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            n_reg      <= '0;
            left_reg   <= '0;
            steps_reg  <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            left_reg   <= left_next;
            steps_reg  <= steps_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        km1_reg  <= km1_next;
        pos_reg  <= pos_next;
        last_reg <= last_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign position      = pos_reg;
    assign last          = last_reg;

endmodule
